// File: rtl/reliable_message_arq_table_macros.svh
// Assertion macros used by the ARQ table datapath.
`ifndef RELIABLE_MESSAGE_ARQ_TABLE_MACROS_SVH
`define RELIABLE_MESSAGE_ARQ_TABLE_MACROS_SVH

// Same-cycle implication, checked on clk, off during reset.
`define RMAT_ASSERT_IMPLY(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, checked on clk, off during reset.
`define RMAT_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// File: rtl/rmat_pkg.sv
// Shared types, constants and command/status structs of the ARQ table.
`timescale 1ns / 1ps
package rmat_pkg;

  localparam int TABLE_DEPTH  = 16;
  localparam int ID_WIDTH     = 16;
  localparam int HANDLE_WIDTH = 8;
  localparam int STAMP_W      = 16;
  localparam int IDX_W        = $clog2(TABLE_DEPTH);
  localparam int CNT_W        = $clog2(TABLE_DEPTH + 1);
  localparam int DATA_W       = ((ID_WIDTH + HANDLE_WIDTH + 7) / 8) * 8;
  localparam int OP_W         = 2;
  localparam int KIND_W       = 3;

  localparam logic [CNT_W-1:0]   DEPTH_C       = CNT_W'(TABLE_DEPTH);
  localparam logic [STAMP_W-1:0] TIMEOUT_RESET = STAMP_W'(80);

  typedef enum logic [OP_W-1:0] {
    OP_SUBMIT,
    OP_ACK,
    OP_DATA,
    OP_TICK
  } op_t;

  typedef enum logic [KIND_W-1:0] {
    KIND_IDLE,
    KIND_TX,
    KIND_RETX,
    KIND_SEND_ACK,
    KIND_DELIVER,
    KIND_ACK_OK,
    KIND_ACK_UNKNOWN,
    KIND_REJECT
  } kind_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DISPATCH,
    ST_ACK_SCAN,
    ST_ACK_SHIFT,
    ST_RX_SCAN,
    ST_RX_ACK,
    ST_TICK_FIND,
    ST_TICK_RESEND,
    ST_TICK_MOVE
  } state_t;

  // Controller to datapath
  typedef struct packed {
    logic  capture;
    logic  idx_clr;
    logic  idx_inc;
    logic  submit;
    logic  ack_shift;
    logic  ack_drop;
    logic  rx_add;
    logic  tick_inc;
    logic  note_exp;
    logic  restamp;
    logic  move;
    logic  emit;
    kind_t kind;
    logic  last;
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    op_t  op;
    logic out_free;
    logic pend_full;
    logic moves;
    logic last_move;
    logic ut_end;
    logic rx_end;
    logic ut_match;
    logic rx_match;
    logic rx_full;
    logic shift_done;
    logic expired;
    logic any_exp;
    logic is_lastexp;
  } stat_t;

endpackage

// File: rtl/rmat_dp.sv
// Datapath of the ARQ table: queues, tables, counters and result register.
`timescale 1ns / 1ps
`include "reliable_message_arq_table_macros.svh"
module rmat_dp (
  input  logic                             clk,
  input  logic                             rst,
  input  rmat_pkg::cmd_t                   cmd,
  output rmat_pkg::stat_t                  stat,
  input  rmat_pkg::op_t                    in_op,
  input  logic [rmat_pkg::ID_WIDTH-1:0]     in_id,
  input  logic [rmat_pkg::HANDLE_WIDTH-1:0] in_handle,
  input  logic                             cfg_valid,
  input  logic [rmat_pkg::STAMP_W-1:0]     cfg_data,
  output logic                             m_valid,
  input  logic                             m_ready,
  output rmat_pkg::kind_t                  m_kind,
  output logic [rmat_pkg::ID_WIDTH-1:0]     m_id,
  output logic [rmat_pkg::HANDLE_WIDTH-1:0] m_handle,
  output logic                             m_last
);
  import rmat_pkg::*;

  // Captured item
  op_t                     op_q;
  logic [ID_WIDTH-1:0]     id_q;
  logic [HANDLE_WIDTH-1:0] handle_q;

  // Stores
  logic [ID_WIDTH-1:0]     pq_id     [TABLE_DEPTH];
  logic [HANDLE_WIDTH-1:0] pq_handle [TABLE_DEPTH];
  logic [ID_WIDTH-1:0]     ut_id     [TABLE_DEPTH];
  logic [HANDLE_WIDTH-1:0] ut_handle [TABLE_DEPTH];
  logic [STAMP_W-1:0]      ut_stamp  [TABLE_DEPTH];
  logic [ID_WIDTH-1:0]     rx_id     [TABLE_DEPTH];

  // Control state
  logic [IDX_W-1:0]    head;
  logic [CNT_W-1:0]    pending_count;
  logic [CNT_W-1:0]    unacked_count;
  logic [CNT_W-1:0]    received_count;
  logic [ID_WIDTH-1:0] next_id;
  logic [STAMP_W-1:0]  tick_now;
  logic [STAMP_W-1:0]  timeout_ticks;
  logic [CNT_W-1:0]    idx;
  logic [CNT_W-1:0]    lastexp;
  logic                any_exp;
  logic                out_free;

  // Address and compare logic
  logic [IDX_W-1:0]        idx_i;
  logic [IDX_W-1:0]        nxt_i;
  logic [CNT_W:0]          tail_sum;
  logic [CNT_W:0]          tail;
  logic [ID_WIDTH-1:0]     ut_rd_id;
  logic [HANDLE_WIDTH-1:0] ut_rd_handle;
  logic [STAMP_W-1:0]      ut_rd_stamp;
  logic [STAMP_W-1:0]      age;
  logic [ID_WIDTH-1:0]     res_id;
  logic [HANDLE_WIDTH-1:0] res_handle;

  assign idx_i = idx[IDX_W-1:0];
  assign nxt_i = IDX_W'(idx + 1'b1);
  assign tail_sum = (CNT_W+1)'(head) + (CNT_W+1)'(pending_count);
  assign tail = (tail_sum >= (CNT_W+1)'(TABLE_DEPTH)) ?
                (CNT_W+1)'(tail_sum - (CNT_W+1)'(TABLE_DEPTH)) : tail_sum;

  assign ut_rd_id     = ut_id[idx_i];
  assign ut_rd_handle = ut_handle[idx_i];
  assign ut_rd_stamp  = ut_stamp[idx_i];
  assign age          = tick_now - ut_rd_stamp;
  assign out_free     = !m_valid || m_ready;

  // Status to controller
  always_comb begin
    stat.op         = op_q;
    stat.out_free   = out_free;
    stat.pend_full  = (pending_count == DEPTH_C);
    stat.moves      = (pending_count != '0) && (unacked_count != DEPTH_C);
    stat.last_move  = (pending_count == CNT_W'(1)) ||
                      (unacked_count == CNT_W'(TABLE_DEPTH - 1));
    stat.ut_end     = (idx == unacked_count);
    stat.rx_end     = (idx == received_count);
    stat.ut_match   = (ut_rd_id == id_q);
    stat.rx_match   = (rx_id[idx_i] == id_q);
    stat.rx_full    = (received_count == DEPTH_C);
    stat.shift_done = (CNT_W'(idx + 1'b1) >= unacked_count);
    stat.expired    = (age >= timeout_ticks);
    stat.any_exp    = any_exp;
    stat.is_lastexp = (idx == lastexp);
  end

  // Result payload select
  always_comb begin
    res_id     = '0;
    res_handle = '0;
    case (cmd.kind)
      KIND_IDLE: begin
        if (op_q == OP_SUBMIT) begin
          res_id     = next_id;
          res_handle = handle_q;
        end
      end
      KIND_REJECT: begin
        if (op_q != OP_SUBMIT) res_id = id_q;
      end
      KIND_ACK_UNKNOWN, KIND_SEND_ACK: res_id = id_q;
      KIND_ACK_OK: begin
        res_id     = id_q;
        res_handle = ut_rd_handle;
      end
      KIND_DELIVER: begin
        res_id     = id_q;
        res_handle = handle_q;
      end
      KIND_RETX: begin
        res_id     = ut_rd_id;
        res_handle = ut_rd_handle;
      end
      KIND_TX: begin
        res_id     = pq_id[head];
        res_handle = pq_handle[head];
      end
      default: begin
        res_id     = '0;
        res_handle = '0;
      end
    endcase
  end

  // Store writes
  always_ff @(posedge clk) begin
    if (cmd.submit) begin
      pq_id[tail[IDX_W-1:0]]     <= next_id;
      pq_handle[tail[IDX_W-1:0]] <= handle_q;
    end
    // Pull the next entry down one slot
    if (cmd.ack_shift) begin
      ut_id[idx_i]     <= ut_id[nxt_i];
      ut_handle[idx_i] <= ut_handle[nxt_i];
      ut_stamp[idx_i]  <= ut_stamp[nxt_i];
    end
    if (cmd.restamp) ut_stamp[idx_i] <= tick_now;
    if (cmd.move) begin
      ut_id[unacked_count[IDX_W-1:0]]     <= pq_id[head];
      ut_handle[unacked_count[IDX_W-1:0]] <= pq_handle[head];
      ut_stamp[unacked_count[IDX_W-1:0]]  <= tick_now;
    end
    if (cmd.rx_add) rx_id[received_count[IDX_W-1:0]] <= id_q;
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      op_q     <= in_op;
      id_q     <= in_id;
      handle_q <= in_handle;
    end
    if (cmd.note_exp && stat.expired) lastexp <= idx;
    if (cmd.emit) begin
      m_kind   <= cmd.kind;
      m_id     <= res_id;
      m_handle <= res_handle;
      m_last   <= cmd.last;
    end
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      head           <= '0;
      pending_count  <= '0;
      unacked_count  <= '0;
      received_count <= '0;
      next_id        <= '0;
      tick_now       <= '0;
      timeout_ticks  <= TIMEOUT_RESET;
      idx            <= '0;
      any_exp        <= 1'b0;
      m_valid        <= 1'b0;
    end else begin
      if (cfg_valid) timeout_ticks <= cfg_data;
      if (cmd.submit) begin
        pending_count <= CNT_W'(pending_count + 1'b1);
        next_id       <= next_id + 1'b1;
      end
      if (cmd.move) begin
        pending_count <= CNT_W'(pending_count - 1'b1);
        unacked_count <= CNT_W'(unacked_count + 1'b1);
        head          <= (head == IDX_W'(TABLE_DEPTH - 1)) ? '0 : IDX_W'(head + 1'b1);
      end
      if (cmd.ack_drop) unacked_count <= CNT_W'(unacked_count - 1'b1);
      if (cmd.rx_add) received_count <= CNT_W'(received_count + 1'b1);
      if (cmd.tick_inc) tick_now <= tick_now + 1'b1;
      if (cmd.capture) any_exp <= 1'b0;
      else if (cmd.note_exp && stat.expired) any_exp <= 1'b1;
      if (cmd.idx_clr) idx <= '0;
      else if (cmd.idx_inc) idx <= CNT_W'(idx + 1'b1);
      if (cmd.emit) m_valid <= 1'b1;
      else if (m_ready) m_valid <= 1'b0;
    end
  end

  `RMAT_ASSERT_IMPLY(a_emit_free, cmd.emit, out_free, "result emitted over a held beat")
  `RMAT_ASSERT_NEXT(a_submit_cnt, cmd.submit, pending_count == CNT_W'($past(pending_count) + 1'b1), "pending count did not grow")
  `RMAT_ASSERT_NEXT(a_drop_cnt, cmd.ack_drop, unacked_count == CNT_W'($past(unacked_count) - 1'b1), "unacked count did not shrink")
  `RMAT_ASSERT_IMPLY(a_move_ok, cmd.move, (pending_count != '0) && (unacked_count != DEPTH_C), "move with empty queue or full table")

endmodule

// File: rtl/rmat_ctrl.sv
// Controller state machine of the ARQ table.
`timescale 1ns / 1ps
module rmat_ctrl (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_ready,
  input  rmat_pkg::stat_t stat,
  output rmat_pkg::cmd_t  cmd
);
  import rmat_pkg::*;

  state_t state;
  state_t state_next;

  // State register
  always_ff @(posedge clk) begin
    if (rst) state <= ST_IDLE;
    else     state <= state_next;
  end

  // Next state and commands
  always_comb begin
    state_next = state;
    cmd        = '0;
    cmd.kind   = KIND_IDLE;
    in_ready   = 1'b0;
    case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.capture = 1'b1;
          cmd.idx_clr = 1'b1;
          state_next  = ST_DISPATCH;
        end
      end
      ST_DISPATCH: begin
        case (stat.op)
          OP_SUBMIT: begin
            if (stat.out_free) begin
              cmd.emit   = 1'b1;
              cmd.last   = 1'b1;
              cmd.kind   = stat.pend_full ? KIND_REJECT : KIND_IDLE;
              cmd.submit = !stat.pend_full;
              state_next = ST_IDLE;
            end
          end
          OP_ACK:  state_next = ST_ACK_SCAN;
          OP_DATA: state_next = ST_RX_SCAN;
          default: begin
            cmd.tick_inc = 1'b1;
            state_next   = ST_TICK_FIND;
          end
        endcase
      end
      // Search the unacked table for the arriving id
      ST_ACK_SCAN: begin
        if (stat.ut_end) begin
          if (stat.out_free) begin
            cmd.emit   = 1'b1;
            cmd.last   = 1'b1;
            cmd.kind   = KIND_ACK_UNKNOWN;
            state_next = ST_IDLE;
          end
        end else if (stat.ut_match) begin
          if (stat.out_free) begin
            cmd.emit   = 1'b1;
            cmd.last   = 1'b1;
            cmd.kind   = KIND_ACK_OK;
            state_next = ST_ACK_SHIFT;
          end
        end else begin
          cmd.idx_inc = 1'b1;
        end
      end
      // Close the gap, one entry a cycle
      ST_ACK_SHIFT: begin
        if (stat.shift_done) begin
          cmd.ack_drop = 1'b1;
          state_next   = ST_IDLE;
        end else begin
          cmd.ack_shift = 1'b1;
          cmd.idx_inc   = 1'b1;
        end
      end
      // Search the received ids
      ST_RX_SCAN: begin
        if (stat.rx_end) begin
          if (stat.out_free) begin
            cmd.emit = 1'b1;
            if (stat.rx_full) begin
              cmd.kind   = KIND_REJECT;
              cmd.last   = 1'b1;
              state_next = ST_IDLE;
            end else begin
              cmd.kind   = KIND_DELIVER;
              cmd.rx_add = 1'b1;
              state_next = ST_RX_ACK;
            end
          end
        end else if (stat.rx_match) begin
          if (stat.out_free) begin
            cmd.emit   = 1'b1;
            cmd.last   = 1'b1;
            cmd.kind   = KIND_SEND_ACK;
            state_next = ST_IDLE;
          end
        end else begin
          cmd.idx_inc = 1'b1;
        end
      end
      ST_RX_ACK: begin
        if (stat.out_free) begin
          cmd.emit   = 1'b1;
          cmd.last   = 1'b1;
          cmd.kind   = KIND_SEND_ACK;
          state_next = ST_IDLE;
        end
      end
      // First pass: find the last expired entry
      ST_TICK_FIND: begin
        if (stat.ut_end) begin
          if (stat.any_exp) begin
            cmd.idx_clr = 1'b1;
            state_next  = ST_TICK_RESEND;
          end else if (stat.moves) begin
            state_next = ST_TICK_MOVE;
          end else if (stat.out_free) begin
            cmd.emit   = 1'b1;
            cmd.last   = 1'b1;
            cmd.kind   = KIND_IDLE;
            state_next = ST_IDLE;
          end
        end else begin
          cmd.note_exp = 1'b1;
          cmd.idx_inc  = 1'b1;
        end
      end
      // Second pass: retransmit and restamp
      ST_TICK_RESEND: begin
        if (stat.ut_end) begin
          state_next = stat.moves ? ST_TICK_MOVE : ST_IDLE;
        end else if (stat.expired) begin
          if (stat.out_free) begin
            cmd.emit    = 1'b1;
            cmd.kind    = KIND_RETX;
            cmd.last    = stat.is_lastexp && !stat.moves;
            cmd.restamp = 1'b1;
            cmd.idx_inc = 1'b1;
            if (cmd.last) state_next = ST_IDLE;
          end
        end else begin
          cmd.idx_inc = 1'b1;
        end
      end
      // Move pending messages into the table
      ST_TICK_MOVE: begin
        if (stat.out_free) begin
          cmd.emit = 1'b1;
          cmd.kind = KIND_TX;
          cmd.move = 1'b1;
          cmd.last = stat.last_move;
          if (stat.last_move) state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

endmodule

// File: rtl/reliable_message_arq_table.sv
// Top level of the ARQ bookkeeping engine: stream ports, controller and datapath.
// Submit: the input beat is captured, then the result is registered on the output; ack and data scan
// the tables at one entry a cycle, and ack removal adds a shift.
// Tick: a pass over the unacked table to find expired entries, a second pass to resend them if any, then moves.
// One item at a time; a result waiting downstream does not block the next input beat.
// Synchronous active-high reset empties all queues and tables and sets the timeout to 80.
`timescale 1ns / 1ps
module reliable_message_arq_table (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         s_axis_tvalid,
  output logic                         s_axis_tready,
  input  logic [rmat_pkg::DATA_W-1:0]  s_axis_tdata,  // msg_id, msg_handle
  input  logic [rmat_pkg::OP_W-1:0]    s_axis_tuser,  // op
  output logic                         m_axis_tvalid,
  input  logic                         m_axis_tready,
  output logic [rmat_pkg::DATA_W-1:0]  m_axis_tdata,  // out_id, out_handle
  output logic [rmat_pkg::KIND_W-1:0]  m_axis_tuser,  // kind
  output logic                         m_axis_tlast,
  input  logic                         cfg_valid,
  output logic                         cfg_ready,
  input  logic [rmat_pkg::STAMP_W-1:0] cfg_data
);
  import rmat_pkg::*;

  cmd_t                    cmd;
  stat_t                   stat;
  kind_t                   m_kind;
  logic [ID_WIDTH-1:0]     m_id;
  logic [HANDLE_WIDTH-1:0] m_handle;

  // Register writes are always taken
  assign cfg_ready = 1'b1;

  rmat_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_axis_tvalid),
    .in_ready (s_axis_tready),
    .stat     (stat),
    .cmd      (cmd)
  );

  rmat_dp u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .stat      (stat),
    .in_op     (op_t'(s_axis_tuser)),
    .in_id     (s_axis_tdata[ID_WIDTH-1:0]),
    .in_handle (s_axis_tdata[ID_WIDTH +: HANDLE_WIDTH]),
    .cfg_valid (cfg_valid),
    .cfg_data  (cfg_data),
    .m_valid   (m_axis_tvalid),
    .m_ready   (m_axis_tready),
    .m_kind    (m_kind),
    .m_id      (m_id),
    .m_handle  (m_handle),
    .m_last    (m_axis_tlast)
  );

  // Pack the result beat
  assign m_axis_tuser = m_kind;
  assign m_axis_tdata = DATA_W'({m_handle, m_id});

endmodule
